### rtl/ipv4_tcp_udp_checksum_verify_defines.svh
// Assertion macros shared by the checksum verifier RTL.
// Each file that asserts includes this header; it depends on nothing else.
`ifndef IPV4_TCP_UDP_CHECKSUM_VERIFY_DEFINES_SVH
`define IPV4_TCP_UDP_CHECKSUM_VERIFY_DEFINES_SVH

// Plain property, sampled on clk, off while rst_n is low.
`define ITUCV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ITUCV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/itucv_pkg.sv
// Shared types, constants and the end-around-carry adder of the checksum verifier.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package itucv_pkg;

  localparam int MAX_FRAME_BYTES = 65535;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;
  localparam logic [3:0]  IP_MIN_IHL    = 4'd5;
  localparam logic [5:0]  IP_MIN_HDR_BYTES = 6'd20;
  localparam logic [15:0] UDP_MIN_LEN   = 16'd8;
  localparam logic [15:0] ETH_HDR_BYTES = 16'd14;

  // Frame byte offsets
  localparam logic [15:0] OFF_ETYPE_HI   = 16'd12;
  localparam logic [15:0] OFF_ETYPE_LO   = 16'd13;
  localparam logic [15:0] OFF_IP_VER_IHL = 16'd14;
  localparam logic [15:0] OFF_TLEN_HI    = 16'd16;
  localparam logic [15:0] OFF_TLEN_LO    = 16'd17;
  localparam logic [15:0] OFF_PROTO      = 16'd23;
  localparam logic [15:0] OFF_IPSUM_HI   = 16'd24;
  localparam logic [15:0] OFF_IPSUM_LO   = 16'd25;
  localparam logic [15:0] OFF_ADDR_FIRST = 16'd26;
  localparam logic [15:0] OFF_ADDR_LAST  = 16'd33;

  // Offsets inside the UDP / TCP header
  localparam logic [15:0] UDP_REL_LEN_HI = 16'd4;
  localparam logic [15:0] UDP_REL_LEN_LO = 16'd5;
  localparam logic [15:0] UDP_REL_SUM_HI = 16'd6;
  localparam logic [15:0] UDP_REL_SUM_LO = 16'd7;
  localparam logic [15:0] TCP_REL_SUM_HI = 16'd16;
  localparam logic [15:0] TCP_REL_SUM_LO = 16'd17;

  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_PTR_W;
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef enum logic [2:0] {
    CLS_OTHER    = 3'd0,
    CLS_ARP      = 3'd1,
    CLS_IP_OTHER = 3'd2,
    CLS_UDP      = 3'd3,
    CLS_TCP      = 3'd4
  } frame_class_t;

  // One queued beat: the lane word and where it goes; header fields ride along
  // and matter only on the last beat of a frame.
  typedef struct packed {
    logic [15:0] word;
    logic        ip_add;
    logic        l4_add;
    logic        last;
    logic [15:0] n_bytes;
    logic [15:0] ethertype;
    logic [3:0]  ihl;
    logic [7:0]  protocol;
    logic [15:0] total_len;
    logic [15:0] udp_len;
    logic [15:0] ip_sum;
    logic [15:0] l4_sum;
  } cmd_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

### rtl/itucv_front.sv
// Front end: counts frame bytes, captures header fields and decides per beat
// which running sums take the byte. Depends on itucv_pkg.
`timescale 1ns / 1ps

module itucv_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic              fifo_full,
  output logic              push,
  output itucv_pkg::cmd_t   push_cmd
);

  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] ethertype_r, ethertype_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [7:0]  protocol_r, protocol_nxt;
  logic [15:0] total_len_r, total_len_nxt;
  logic [15:0] udp_len_r, udp_len_nxt;
  logic [15:0] ip_sum_r, ip_sum_nxt;
  logic [15:0] l4_sum_r, l4_sum_nxt;

  logic [15:0] off;
  logic        take;
  logic        is_ip;
  logic [5:0]  hdr_bytes;
  logic [15:0] hdr_end;
  logic        udp_k, tcp_k;
  logic        l4_on, seg_on, skip;
  logic [15:0] rel;
  logic [15:0] seg_len;
  logic [15:0] span;

  assign in_ready = !fifo_full;
  assign push     = in_valid && in_ready;
  assign off      = byte_count_r;

  always_comb begin
    take          = push && (byte_count_r < 16'(itucv_pkg::MAX_FRAME_BYTES));
    byte_count_nxt = take ? byte_count_r + 16'd1 : byte_count_r;
    ethertype_nxt = ethertype_r;
    ihl_nxt       = ihl_r;
    protocol_nxt  = protocol_r;
    total_len_nxt = total_len_r;
    udp_len_nxt   = udp_len_r;
    ip_sum_nxt    = ip_sum_r;
    l4_sum_nxt    = l4_sum_r;
    skip          = 1'b0;

    if (take && off == itucv_pkg::OFF_ETYPE_HI) begin
      ethertype_nxt = {in_data_byte, 8'h00};
    end
    if (take && off == itucv_pkg::OFF_ETYPE_LO) begin
      ethertype_nxt = {ethertype_r[15:8], ethertype_r[7:0] | in_data_byte};
    end

    is_ip = take && off >= itucv_pkg::OFF_IP_VER_IHL
            && ethertype_r == itucv_pkg::ETH_TYPE_IPV4;

    if (is_ip) begin
      if (off == itucv_pkg::OFF_IP_VER_IHL) ihl_nxt = in_data_byte[3:0];
      if (off == itucv_pkg::OFF_TLEN_HI) total_len_nxt = {in_data_byte, 8'h00};
      if (off == itucv_pkg::OFF_TLEN_LO) total_len_nxt = {total_len_r[15:8], in_data_byte};
      if (off == itucv_pkg::OFF_PROTO) protocol_nxt = in_data_byte;
      if (off == itucv_pkg::OFF_IPSUM_HI) ip_sum_nxt = {in_data_byte, 8'h00};
      if (off == itucv_pkg::OFF_IPSUM_LO) ip_sum_nxt = {ip_sum_r[15:8], in_data_byte};
    end

    hdr_bytes = {ihl_nxt, 2'b00};
    hdr_end   = itucv_pkg::OFF_IP_VER_IHL + {10'd0, hdr_bytes};
    udp_k     = ihl_nxt >= itucv_pkg::IP_MIN_IHL && protocol_nxt == itucv_pkg::IP_PROTO_UDP;
    tcp_k     = ihl_nxt >= itucv_pkg::IP_MIN_IHL && protocol_nxt == itucv_pkg::IP_PROTO_TCP;
    l4_on     = is_ip && off >= itucv_pkg::OFF_ADDR_FIRST && (udp_k || tcp_k);
    seg_on    = l4_on && off >= hdr_end;
    rel       = off - hdr_end;

    if (seg_on && udp_k) begin
      if (rel == itucv_pkg::UDP_REL_LEN_HI) udp_len_nxt = {in_data_byte, 8'h00};
      if (rel == itucv_pkg::UDP_REL_LEN_LO) udp_len_nxt = {udp_len_r[15:8], in_data_byte};
      if (rel == itucv_pkg::UDP_REL_SUM_HI) l4_sum_nxt = {in_data_byte, 8'h00};
      if (rel == itucv_pkg::UDP_REL_SUM_LO) l4_sum_nxt = {l4_sum_r[15:8], in_data_byte};
      skip = rel == itucv_pkg::UDP_REL_SUM_HI || rel == itucv_pkg::UDP_REL_SUM_LO;
    end
    if (seg_on && tcp_k) begin
      if (rel == itucv_pkg::TCP_REL_SUM_HI) l4_sum_nxt = {in_data_byte, 8'h00};
      if (rel == itucv_pkg::TCP_REL_SUM_LO) l4_sum_nxt = {l4_sum_r[15:8], in_data_byte};
      skip = rel == itucv_pkg::TCP_REL_SUM_HI || rel == itucv_pkg::TCP_REL_SUM_LO;
    end

    seg_len = total_len_nxt - {10'd0, hdr_bytes};
    if (udp_k) begin
      span = (udp_len_nxt < itucv_pkg::UDP_MIN_LEN) ? itucv_pkg::UDP_MIN_LEN : udp_len_nxt;
    end else begin
      span = seg_len;
    end

    push_cmd.word      = off[0] ? {8'h00, in_data_byte} : {in_data_byte, 8'h00};
    push_cmd.ip_add    = is_ip && off < hdr_end
                         && off != itucv_pkg::OFF_IPSUM_HI && off != itucv_pkg::OFF_IPSUM_LO;
    push_cmd.l4_add    = (l4_on && off <= itucv_pkg::OFF_ADDR_LAST)
                         || (seg_on && !skip && rel < span);
    push_cmd.last      = in_last_byte;
    push_cmd.n_bytes   = byte_count_nxt;
    push_cmd.ethertype = ethertype_nxt;
    push_cmd.ihl       = ihl_nxt;
    push_cmd.protocol  = protocol_nxt;
    push_cmd.total_len = total_len_nxt;
    push_cmd.udp_len   = udp_len_nxt;
    push_cmd.ip_sum    = ip_sum_nxt;
    push_cmd.l4_sum    = l4_sum_nxt;
  end

  // Drop all frame state once the last beat is queued.
  always_ff @(posedge clk) begin
    if (!rst_n || (push && in_last_byte)) begin
      byte_count_r <= '0;
      ethertype_r  <= '0;
      ihl_r        <= '0;
      protocol_r   <= '0;
      total_len_r  <= '0;
      udp_len_r    <= '0;
      ip_sum_r     <= '0;
      l4_sum_r     <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      ethertype_r  <= ethertype_nxt;
      ihl_r        <= ihl_nxt;
      protocol_r   <= protocol_nxt;
      total_len_r  <= total_len_nxt;
      udp_len_r    <= udp_len_nxt;
      ip_sum_r     <= ip_sum_nxt;
      l4_sum_r     <= l4_sum_nxt;
    end
  end

endmodule

### rtl/itucv_fifo.sv
// Short beat queue between the front end and the summing back end.
// Depends on itucv_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "ipv4_tcp_udp_checksum_verify_defines.svh"

module itucv_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  itucv_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output itucv_pkg::cmd_t pop_data,
  output logic            empty
);

  itucv_pkg::cmd_t                   mem_r [itucv_pkg::FIFO_DEPTH];
  logic [itucv_pkg::FIFO_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [itucv_pkg::FIFO_CNT_W-1:0]  count_r, count_nxt;

  assign full     = count_r == itucv_pkg::FIFO_CNT_W'(itucv_pkg::FIFO_DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + itucv_pkg::FIFO_CNT_W'(1);
    if (pop && !push) count_nxt = count_r - itucv_pkg::FIFO_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + itucv_pkg::FIFO_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + itucv_pkg::FIFO_PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ITUCV_ASSERT(a_fifo_count_range, count_r <= itucv_pkg::FIFO_CNT_W'(itucv_pkg::FIFO_DEPTH), "queue count above depth")
  `ITUCV_ASSERT_IMP(a_fifo_empty_ptrs, count_r == '0, rd_ptr_r == wr_ptr_r, "empty queue with split pointers")
  `ITUCV_ASSERT_IMP(a_fifo_push_room, push, !full, "beat pushed into a full queue")

endmodule

### rtl/itucv_back.sv
// Back end: runs the two end-around-carry sums, then finishes one result per
// frame through two stages into the output register. Depends on itucv_pkg and
// the assertion macros header.
`timescale 1ns / 1ps
`include "ipv4_tcp_udp_checksum_verify_defines.svh"

module itucv_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fifo_empty,
  input  itucv_pkg::cmd_t fifo_data,
  output logic            fifo_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_frame_class,
  output logic [5:0]      out_ip_header_bytes,
  output logic [15:0]     out_ip_sum_received,
  output logic [15:0]     out_ip_sum_computed,
  output logic [15:0]     out_l4_sum_received,
  output logic [15:0]     out_l4_sum_computed,
  output logic [15:0]     out_l4_length,
  output logic            out_truncated
);

  typedef struct packed {
    logic [15:0] ip_acc;
    logic [15:0] l4_acc;
    logic [15:0] n_bytes;
    logic [15:0] ethertype;
    logic [3:0]  ihl;
    logic [7:0]  protocol;
    logic [15:0] total_len;
    logic [15:0] udp_len;
    logic [15:0] ip_sum;
    logic [15:0] l4_sum;
  } fin1_t;

  typedef struct packed {
    itucv_pkg::frame_class_t cls;
    logic        short_frame;
    logic        is_ip;
    logic        is_l4;
    logic [5:0]  hdr_bytes;
    logic [15:0] ip_sum;
    logic [15:0] ip_calc;
    logic [15:0] l4_sum;
    logic [15:0] l4_pre;
    logic [15:0] seg_len;
    logic [15:0] span;
    logic [6:0]  need_hdr;
    logic [15:0] n_bytes;
  } fin2_t;

  typedef struct packed {
    itucv_pkg::frame_class_t cls;
    logic [5:0]  hdr_bytes;
    logic [15:0] ip_sum;
    logic [15:0] ip_calc;
    logic [15:0] l4_sum;
    logic [15:0] l4_calc;
    logic [15:0] l4_len;
    logic        trunc;
  } res_t;

  logic [15:0] ip_acc_r, l4_acc_r;
  logic [15:0] ip_acc_nxt, l4_acc_nxt;
  logic        stage_en;
  logic        pop_last;
  logic        f1_valid_r, f2_valid_r, out_valid_r;
  fin1_t       f1_r, f1_nxt;
  fin2_t       f2_r, f2_nxt;
  res_t        out_r, out_nxt;
  logic        udp_k, tcp_k, is_arp;
  logic [16:0] need_l4;
  logic [16:0] need;

  // Everything past the accumulators moves only while the output can take a result.
  assign stage_en = !out_valid_r || out_ready;
  assign fifo_pop = !fifo_empty && (!fifo_data.last || stage_en);
  assign pop_last = fifo_pop && fifo_data.last;

  always_comb begin
    ip_acc_nxt = fifo_data.ip_add ? itucv_pkg::oc_add(ip_acc_r, fifo_data.word) : ip_acc_r;
    l4_acc_nxt = fifo_data.l4_add ? itucv_pkg::oc_add(l4_acc_r, fifo_data.word) : l4_acc_r;

    f1_nxt.ip_acc    = ip_acc_nxt;
    f1_nxt.l4_acc    = l4_acc_nxt;
    f1_nxt.n_bytes   = fifo_data.n_bytes;
    f1_nxt.ethertype = fifo_data.ethertype;
    f1_nxt.ihl       = fifo_data.ihl;
    f1_nxt.protocol  = fifo_data.protocol;
    f1_nxt.total_len = fifo_data.total_len;
    f1_nxt.udp_len   = fifo_data.udp_len;
    f1_nxt.ip_sum    = fifo_data.ip_sum;
    f1_nxt.l4_sum    = fifo_data.l4_sum;
  end

  // Classify and start the pseudo-header fold.
  always_comb begin
    f2_nxt.short_frame = f1_r.n_bytes < itucv_pkg::ETH_HDR_BYTES;
    f2_nxt.is_ip = !f2_nxt.short_frame && f1_r.ethertype == itucv_pkg::ETH_TYPE_IPV4;
    is_arp       = !f2_nxt.short_frame && f1_r.ethertype == itucv_pkg::ETH_TYPE_ARP;
    udp_k = f2_nxt.is_ip && f1_r.ihl >= itucv_pkg::IP_MIN_IHL
            && f1_r.protocol == itucv_pkg::IP_PROTO_UDP;
    tcp_k = f2_nxt.is_ip && f1_r.ihl >= itucv_pkg::IP_MIN_IHL
            && f1_r.protocol == itucv_pkg::IP_PROTO_TCP;
    f2_nxt.is_l4 = udp_k || tcp_k;

    priority if (udp_k) begin
      f2_nxt.cls = itucv_pkg::CLS_UDP;
    end else if (tcp_k) begin
      f2_nxt.cls = itucv_pkg::CLS_TCP;
    end else if (f2_nxt.is_ip) begin
      f2_nxt.cls = itucv_pkg::CLS_IP_OTHER;
    end else if (is_arp) begin
      f2_nxt.cls = itucv_pkg::CLS_ARP;
    end else begin
      f2_nxt.cls = itucv_pkg::CLS_OTHER;
    end

    f2_nxt.hdr_bytes = {f1_r.ihl, 2'b00};
    f2_nxt.ip_sum    = f1_r.ip_sum;
    f2_nxt.ip_calc   = ~f1_r.ip_acc;
    f2_nxt.l4_sum    = f1_r.l4_sum;
    f2_nxt.l4_pre    = itucv_pkg::oc_add(f1_r.l4_acc, {8'h00, f1_r.protocol});
    f2_nxt.seg_len   = f1_r.total_len - {10'd0, f2_nxt.hdr_bytes};
    if (udp_k) begin
      f2_nxt.span = (f1_r.udp_len < itucv_pkg::UDP_MIN_LEN) ? itucv_pkg::UDP_MIN_LEN
                                                            : f1_r.udp_len;
    end else begin
      f2_nxt.span = f2_nxt.seg_len;
    end
    f2_nxt.need_hdr = 7'(itucv_pkg::ETH_HDR_BYTES)
                      + {1'b0, (f2_nxt.hdr_bytes < itucv_pkg::IP_MIN_HDR_BYTES)
                               ? itucv_pkg::IP_MIN_HDR_BYTES : f2_nxt.hdr_bytes};
    f2_nxt.n_bytes = f1_r.n_bytes;
  end

  // Close the sum, check length, zero what the class does not report.
  always_comb begin
    need_l4 = 17'(itucv_pkg::ETH_HDR_BYTES) + 17'(f2_r.hdr_bytes) + {1'b0, f2_r.span};
    need    = f2_r.is_l4 ? need_l4 : {10'd0, f2_r.need_hdr};

    out_nxt.cls       = f2_r.cls;
    out_nxt.hdr_bytes = f2_r.is_ip ? f2_r.hdr_bytes : '0;
    out_nxt.ip_sum    = f2_r.is_ip ? f2_r.ip_sum : '0;
    out_nxt.ip_calc   = f2_r.is_ip ? f2_r.ip_calc : '0;
    out_nxt.l4_sum    = f2_r.is_l4 ? f2_r.l4_sum : '0;
    out_nxt.l4_calc   = f2_r.is_l4 ? ~itucv_pkg::oc_add(f2_r.l4_pre, f2_r.seg_len) : '0;
    out_nxt.l4_len    = f2_r.is_l4 ? f2_r.seg_len : '0;
    out_nxt.trunc     = f2_r.short_frame || (f2_r.is_ip && ({1'b0, f2_r.n_bytes} < need));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_acc_r <= '0;
      l4_acc_r <= '0;
    end else if (fifo_pop) begin
      ip_acc_r <= fifo_data.last ? '0 : ip_acc_nxt;
      l4_acc_r <= fifo_data.last ? '0 : l4_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r  <= 1'b0;
      f2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (stage_en) begin
      f1_valid_r  <= pop_last;
      f2_valid_r  <= f1_valid_r;
      out_valid_r <= f2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      f1_r  <= f1_nxt;
      f2_r  <= f2_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_class     = out_r.cls;
  assign out_ip_header_bytes = out_r.hdr_bytes;
  assign out_ip_sum_received = out_r.ip_sum;
  assign out_ip_sum_computed = out_r.ip_calc;
  assign out_l4_sum_received = out_r.l4_sum;
  assign out_l4_sum_computed = out_r.l4_calc;
  assign out_l4_length       = out_r.l4_len;
  assign out_truncated       = out_r.trunc;

  `ITUCV_ASSERT_IMP(a_back_out_from_pipe, $rose(out_valid_r), $past(f2_valid_r), "result without a finished frame")
  `ITUCV_ASSERT_IMP(a_back_l4_zero, out_valid_r && out_r.cls != itucv_pkg::CLS_UDP && out_r.cls != itucv_pkg::CLS_TCP, out_r.l4_len == '0 && out_r.l4_sum == '0 && out_r.l4_calc == '0, "segment fields set on a frame with no segment sum")
  `ITUCV_ASSERT_IMP(a_back_out_hold, $past(rst_n && out_valid_r && !out_ready), out_valid_r && $stable(out_r), "result dropped or changed while stalled")

endmodule

### rtl/ipv4_tcp_udp_checksum_verify.sv
// Byte-stream IPv4 / UDP / TCP checksum verifier, top level.
// Uses itucv_pkg, itucv_front, itucv_fifo and itucv_back.
//
// Feed an Ethernet frame one byte per beat, destination address first, with
// in_last_byte on the final byte. The block sustains one byte per clock: each
// byte costs one 16-bit end-around add in the back end, and the front end
// decides which sums it joins in the same cycle it is accepted. A four-entry
// beat queue separates the two, so input keeps flowing while a result waits
// on out_ready; input stalls only once the queue fills behind an untaken
// result. Each frame gives exactly one result; its last byte goes through the
// queue write, the final sums into the first finishing stage, the second
// finishing stage and the output register. Bytes past offset 65534 are
// ignored but the frame still ends on its last mark.
`timescale 1ns / 1ps

module ipv4_tcp_udp_checksum_verify (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_frame_class,
  output logic [5:0]  out_ip_header_bytes,
  output logic [15:0] out_ip_sum_received,
  output logic [15:0] out_ip_sum_computed,
  output logic [15:0] out_l4_sum_received,
  output logic [15:0] out_l4_sum_computed,
  output logic [15:0] out_l4_length,
  output logic        out_truncated
);

  logic            fifo_full;
  logic            fifo_empty;
  logic            push;
  logic            pop;
  itucv_pkg::cmd_t push_cmd;
  itucv_pkg::cmd_t pop_cmd;

  itucv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  itucv_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .empty     (fifo_empty)
  );

  itucv_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .fifo_empty          (fifo_empty),
    .fifo_data           (pop_cmd),
    .fifo_pop            (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_class     (out_frame_class),
    .out_ip_header_bytes (out_ip_header_bytes),
    .out_ip_sum_received (out_ip_sum_received),
    .out_ip_sum_computed (out_ip_sum_computed),
    .out_l4_sum_received (out_l4_sum_received),
    .out_l4_sum_computed (out_l4_sum_computed),
    .out_l4_length       (out_l4_length),
    .out_truncated       (out_truncated)
  );

endmodule

### tb/tb_top.sv
// Self-checking bench for ipv4_tcp_udp_checksum_verify: streams Ethernet frames byte by byte
// and checks each per-frame result against a byte-level model of the checksum rules.
// Depends on itucv_pkg and the RTL of the block only.
`timescale 1ns / 1ps

typedef struct packed {
  itucv_pkg::frame_class_t frame_class;
  logic [5:0]   ip_header_bytes;
  logic [15:0]  ip_sum_received;
  logic [15:0]  ip_sum_computed;
  logic [15:0]  l4_sum_received;
  logic [15:0]  l4_sum_computed;
  logic [15:0]  l4_length;
  logic         truncated;
} frame_verdict_t;

class checksum_scoreboard;
  logic [15:0] frame_pos;
  logic [15:0] ethertype;
  logic [3:0]  ihl;
  logic [7:0]  protocol;
  logic [15:0] total_len;
  logic [15:0] udp_len;
  logic [15:0] ip_acc;
  logic [15:0] l4_acc;
  logic [15:0] ip_sum_seen;
  logic [15:0] l4_sum_seen;
  frame_verdict_t verdicts_due[$];
  int unsigned mismatches;
  int unsigned results_seen;

  function new();
    clear_frame();
    mismatches = 0;
    results_seen = 0;
  endfunction

  function void clear_frame();
    frame_pos = '0;
    ethertype = '0;
    ihl = '0;
    protocol = '0;
    total_len = '0;
    udp_len = '0;
    ip_acc = '0;
    l4_acc = '0;
    ip_sum_seen = '0;
    l4_sum_seen = '0;
  endfunction

  // ones'-complement add with end-around carry
  function logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function itucv_pkg::frame_class_t l4_class();
    if (ihl < itucv_pkg::IP_MIN_IHL) return itucv_pkg::CLS_OTHER;
    if (protocol == itucv_pkg::IP_PROTO_UDP) return itucv_pkg::CLS_UDP;
    if (protocol == itucv_pkg::IP_PROTO_TCP) return itucv_pkg::CLS_TCP;
    return itucv_pkg::CLS_OTHER;
  endfunction

  function logic [15:0] seg_len();
    return total_len - {10'd0, ihl, 2'b00};
  endfunction

  function int unsigned seg_span(input itucv_pkg::frame_class_t k);
    if (k == itucv_pkg::CLS_UDP)
      return (udp_len < itucv_pkg::UDP_MIN_LEN) ? itucv_pkg::UDP_MIN_LEN : udp_len;
    return seg_len();
  endfunction

  function void take_byte(input int unsigned off, input logic [7:0] b);
    logic [15:0]             word;
    int unsigned             hdr_bytes;
    int unsigned             first_l4;
    int unsigned             rel;
    itucv_pkg::frame_class_t k;
    bit                      skip;
    word = off[0] ? {8'h00, b} : {b, 8'h00};
    if (off == itucv_pkg::OFF_ETYPE_HI) ethertype = {b, 8'h00};
    if (off == itucv_pkg::OFF_ETYPE_LO) ethertype[7:0] = b;
    if (off < itucv_pkg::ETH_HDR_BYTES || ethertype != itucv_pkg::ETH_TYPE_IPV4) return;

    if (off == itucv_pkg::OFF_IP_VER_IHL) ihl = b[3:0];
    if (off == itucv_pkg::OFF_TLEN_HI) total_len = {b, 8'h00};
    if (off == itucv_pkg::OFF_TLEN_LO) total_len[7:0] = b;
    if (off == itucv_pkg::OFF_PROTO) protocol = b;
    if (off == itucv_pkg::OFF_IPSUM_HI) ip_sum_seen = {b, 8'h00};
    if (off == itucv_pkg::OFF_IPSUM_LO) ip_sum_seen[7:0] = b;

    hdr_bytes = int'(ihl) * 4;
    if (off < itucv_pkg::ETH_HDR_BYTES + hdr_bytes && off != itucv_pkg::OFF_IPSUM_HI
        && off != itucv_pkg::OFF_IPSUM_LO)
      ip_acc = fold_add(ip_acc, word);

    if (off < itucv_pkg::OFF_ADDR_FIRST) return;
    k = l4_class();
    if (k == itucv_pkg::CLS_OTHER) return;
    // addresses join the pseudo-header
    if (off <= itucv_pkg::OFF_ADDR_LAST) l4_acc = fold_add(l4_acc, word);

    first_l4 = itucv_pkg::ETH_HDR_BYTES + hdr_bytes;
    if (off < first_l4) return;
    rel = off - first_l4;
    if (k == itucv_pkg::CLS_UDP) begin
      if (rel == itucv_pkg::UDP_REL_LEN_HI) udp_len = {b, 8'h00};
      if (rel == itucv_pkg::UDP_REL_LEN_LO) udp_len[7:0] = b;
      if (rel == itucv_pkg::UDP_REL_SUM_HI) l4_sum_seen = {b, 8'h00};
      if (rel == itucv_pkg::UDP_REL_SUM_LO) l4_sum_seen[7:0] = b;
      skip = (rel == itucv_pkg::UDP_REL_SUM_HI || rel == itucv_pkg::UDP_REL_SUM_LO);
    end else begin
      if (rel == itucv_pkg::TCP_REL_SUM_HI) l4_sum_seen = {b, 8'h00};
      if (rel == itucv_pkg::TCP_REL_SUM_LO) l4_sum_seen[7:0] = b;
      skip = (rel == itucv_pkg::TCP_REL_SUM_HI || rel == itucv_pkg::TCP_REL_SUM_LO);
    end
    if (!skip && rel < seg_span(k)) l4_acc = fold_add(l4_acc, word);
  endfunction

  function void note_byte(input logic [7:0] b, input logic last);
    frame_verdict_t          v;
    int unsigned             hdr_bytes;
    int unsigned             need;
    itucv_pkg::frame_class_t k;
    logic [15:0]             acc;
    // drop bytes past the counter limit, the frame still ends on its mark
    if (frame_pos < itucv_pkg::MAX_FRAME_BYTES) begin
      take_byte(frame_pos, b);
      frame_pos++;
    end
    if (!last) return;

    v = '0;
    if (frame_pos < itucv_pkg::ETH_HDR_BYTES) begin
      v.truncated = 1'b1;
    end else if (ethertype == itucv_pkg::ETH_TYPE_ARP) begin
      v.frame_class = itucv_pkg::CLS_ARP;
    end else if (ethertype == itucv_pkg::ETH_TYPE_IPV4) begin
      hdr_bytes = int'(ihl) * 4;
      k = l4_class();
      need = itucv_pkg::ETH_HDR_BYTES + ((hdr_bytes < itucv_pkg::IP_MIN_HDR_BYTES)
                                         ? itucv_pkg::IP_MIN_HDR_BYTES : hdr_bytes);
      v.frame_class = (k != itucv_pkg::CLS_OTHER) ? k : itucv_pkg::CLS_IP_OTHER;
      v.ip_header_bytes = hdr_bytes[5:0];
      v.ip_sum_received = ip_sum_seen;
      v.ip_sum_computed = ~ip_acc;
      if (k != itucv_pkg::CLS_OTHER) begin
        acc = fold_add(fold_add(l4_acc, {8'h00, protocol}), seg_len());
        v.l4_sum_received = l4_sum_seen;
        v.l4_sum_computed = ~acc;
        v.l4_length = seg_len();
        need = itucv_pkg::ETH_HDR_BYTES + hdr_bytes + seg_span(k);
      end
      v.truncated = (frame_pos < need);
    end
    verdicts_due.push_back(v);
    clear_frame();
  endfunction

  function void compare_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: result %0d %s expected %h got %h", $time, results_seen, name, want, got);
    end
  endfunction

  function void check_result(input frame_verdict_t got);
    frame_verdict_t want;
    results_seen++;
    if (verdicts_due.size() == 0) begin
      mismatches++;
      $display("%0t: result %0d with no frame pending, class %0d", $time, results_seen,
               got.frame_class);
      return;
    end
    want = verdicts_due.pop_front();
    compare_field("frame_class", want.frame_class, got.frame_class);
    compare_field("ip_header_bytes", want.ip_header_bytes, got.ip_header_bytes);
    compare_field("ip_sum_received", want.ip_sum_received, got.ip_sum_received);
    compare_field("ip_sum_computed", want.ip_sum_computed, got.ip_sum_computed);
    compare_field("l4_sum_received", want.l4_sum_received, got.l4_sum_received);
    compare_field("l4_sum_computed", want.l4_sum_computed, got.l4_sum_computed);
    compare_field("l4_length", want.l4_length, got.l4_length);
    compare_field("truncated", want.truncated, got.truncated);
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT       = 500000;
  localparam int RANDOM_BYTES      = 800;
  localparam int MIN_RANDOM_FRAMES = 16;
  localparam int DRAIN_CYCLES      = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_frame_class;
  logic [5:0]  out_ip_header_bytes;
  logic [15:0] out_ip_sum_received;
  logic [15:0] out_ip_sum_computed;
  logic [15:0] out_l4_sum_received;
  logic [15:0] out_l4_sum_computed;
  logic [15:0] out_l4_length;
  logic        out_truncated;

  checksum_scoreboard sb;
  logic [7:0]  frame_q[$];
  int          send_idle_pct = 12;
  int          recv_idle_pct = 63;
  int unsigned cycle_count = 0;
  int          rand_bytes = 0;
  int          rand_frames = 0;

  ipv4_tcp_udp_checksum_verify dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_class     (out_frame_class),
    .out_ip_header_bytes (out_ip_header_bytes),
    .out_ip_sum_received (out_ip_sum_received),
    .out_ip_sum_computed (out_ip_sum_computed),
    .out_l4_sum_received (out_l4_sum_received),
    .out_l4_sum_computed (out_l4_sum_computed),
    .out_l4_length       (out_l4_length),
    .out_truncated       (out_truncated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : take_result
    frame_verdict_t got;
    if (rst_n && out_valid && out_ready) begin
      got.frame_class     = itucv_pkg::frame_class_t'(out_frame_class);
      got.ip_header_bytes = out_ip_header_bytes;
      got.ip_sum_received = out_ip_sum_received;
      got.ip_sum_computed = out_ip_sum_computed;
      got.l4_sum_received = out_l4_sum_received;
      got.l4_sum_computed = out_l4_sum_computed;
      got.l4_length       = out_l4_length;
      got.truncated       = out_truncated;
      sb.check_result(got);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic drive_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) drive_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  function automatic logic [7:0] fill_byte(input int fill);
    if (fill < 0) return 8'($urandom_range(0, 255));
    return fill[7:0];
  endfunction

  function automatic void put_word(input int idx, input logic [15:0] w);
    if (idx + 1 < frame_q.size()) begin
      frame_q[idx] = w[15:8];
      frame_q[idx + 1] = w[7:0];
    end
  endfunction

  function automatic void cut_frame(input int keep);
    while (frame_q.size() > keep) void'(frame_q.pop_back());
  endfunction

  // Consistent IPv4 frame; a negative fill means random content.
  function automatic void build_ip_frame(input logic [7:0] proto, input logic [3:0] ihl,
                                         input int payload_len, input int fill);
    int hdr_written;
    int l4_hdr;
    int total;
    frame_q.delete();
    hdr_written = (ihl < itucv_pkg::IP_MIN_IHL) ? itucv_pkg::IP_MIN_HDR_BYTES : int'(ihl) * 4;
    l4_hdr = (proto == itucv_pkg::IP_PROTO_UDP) ? 8
             : (proto == itucv_pkg::IP_PROTO_TCP) ? 20 : 0;
    total = int'(ihl) * 4 + l4_hdr + payload_len;
    repeat (12) frame_q.push_back(fill_byte(fill));
    frame_q.push_back(itucv_pkg::ETH_TYPE_IPV4[15:8]);
    frame_q.push_back(itucv_pkg::ETH_TYPE_IPV4[7:0]);
    frame_q.push_back({4'h4, ihl});
    repeat (hdr_written - 1 + l4_hdr + payload_len) frame_q.push_back(fill_byte(fill));
    put_word(itucv_pkg::OFF_TLEN_HI, total[15:0]);
    frame_q[itucv_pkg::OFF_PROTO] = proto;
    if (proto == itucv_pkg::IP_PROTO_UDP)
      put_word(itucv_pkg::ETH_HDR_BYTES + hdr_written + itucv_pkg::UDP_REL_LEN_HI,
               16'(l4_hdr + payload_len));
  endfunction

  function automatic void build_random_frame();
    int         pick;
    int         hdr_written;
    logic [7:0] proto;
    logic [3:0] ihl;
    frame_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 13)) frame_q.push_back(fill_byte(-1));
    end else if (pick < 14) begin
      repeat (12) frame_q.push_back(fill_byte(-1));
      frame_q.push_back(itucv_pkg::ETH_TYPE_ARP[15:8]);
      frame_q.push_back(itucv_pkg::ETH_TYPE_ARP[7:0]);
      repeat ($urandom_range(0, 18)) frame_q.push_back(fill_byte(-1));
    end else if (pick < 20) begin
      repeat ($urandom_range(14, 40)) frame_q.push_back(fill_byte(-1));
    end else begin
      pick = $urandom_range(0, 99);
      proto = (pick < 45) ? itucv_pkg::IP_PROTO_UDP
              : (pick < 85) ? itucv_pkg::IP_PROTO_TCP : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      ihl = (pick < 80) ? itucv_pkg::IP_MIN_IHL
            : (pick < 90) ? 4'($urandom_range(6, 15)) : 4'($urandom_range(0, 4));
      build_ip_frame(proto, ihl,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                 : $urandom_range(0, 16), -1);
      hdr_written = (ihl < itucv_pkg::IP_MIN_IHL) ? itucv_pkg::IP_MIN_HDR_BYTES
                                                  : int'(ihl) * 4;
      pick = $urandom_range(0, 99);
      if (pick < 8) put_word(itucv_pkg::OFF_TLEN_HI, 16'($urandom));
      else if (pick < 14) put_word(itucv_pkg::OFF_TLEN_HI, 16'($urandom_range(0, 80)));
      pick = $urandom_range(0, 99);
      if (proto == itucv_pkg::IP_PROTO_UDP && pick < 12)
        put_word(itucv_pkg::ETH_HDR_BYTES + hdr_written + itucv_pkg::UDP_REL_LEN_HI,
                 (pick < 8) ? 16'($urandom_range(0, 15)) : 16'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 15) cut_frame($urandom_range(1, frame_q.size() - 1));
      else if (pick < 30) repeat ($urandom_range(1, 20)) frame_q.push_back(fill_byte(-1));
    end
  endfunction

  task automatic run_directed_frames();
    // single byte, all ones
    frame_q = '{8'hFF};
    send_frame();
    // Ethernet header one byte short
    frame_q.delete();
    repeat (13) frame_q.push_back(8'h00);
    send_frame();
    // minimal ARP
    frame_q.delete();
    repeat (12) frame_q.push_back(8'hFF);
    frame_q.push_back(itucv_pkg::ETH_TYPE_ARP[15:8]);
    frame_q.push_back(itucv_pkg::ETH_TYPE_ARP[7:0]);
    send_frame();
    // unknown EtherType, body ignored
    frame_q.delete();
    repeat (12) frame_q.push_back(fill_byte(-1));
    frame_q.push_back(8'h86);
    frame_q.push_back(8'hDD);
    repeat (10) frame_q.push_back(fill_byte(-1));
    send_frame();
    // UDP, odd payload so the last byte pads with zero
    build_ip_frame(itucv_pkg::IP_PROTO_UDP, itucv_pkg::IP_MIN_IHL, 3, 255);
    send_frame();
    build_ip_frame(itucv_pkg::IP_PROTO_UDP, itucv_pkg::IP_MIN_IHL, 4, 0);
    send_frame();
    // TCP with Ethernet padding past the IP total length
    build_ip_frame(itucv_pkg::IP_PROTO_TCP, itucv_pkg::IP_MIN_IHL, 1, -1);
    repeat (14) frame_q.push_back(fill_byte(-1));
    send_frame();
    // UDP length below the header size
    build_ip_frame(itucv_pkg::IP_PROTO_UDP, itucv_pkg::IP_MIN_IHL, 6, -1);
    put_word(itucv_pkg::ETH_HDR_BYTES + itucv_pkg::IP_MIN_HDR_BYTES
             + itucv_pkg::UDP_REL_LEN_HI, 16'd0);
    send_frame();
    // IHL under five: IPv4 other, short header sum
    build_ip_frame(itucv_pkg::IP_PROTO_UDP, 4'd3, 8, -1);
    send_frame();
    build_ip_frame(itucv_pkg::IP_PROTO_TCP, 4'd0, 4, -1);
    send_frame();
    // largest header, with options
    build_ip_frame(itucv_pkg::IP_PROTO_TCP, 4'd15, 2, -1);
    send_frame();
    build_ip_frame(8'd1, itucv_pkg::IP_MIN_IHL, 9, -1);
    send_frame();
    // cut inside the UDP header
    build_ip_frame(itucv_pkg::IP_PROTO_UDP, itucv_pkg::IP_MIN_IHL, 10, -1);
    cut_frame(38);
    send_frame();
    // cut inside the IPv4 header
    build_ip_frame(itucv_pkg::IP_PROTO_TCP, itucv_pkg::IP_MIN_IHL, 0, -1);
    cut_frame(20);
    send_frame();
    // total length under the header length: segment length wraps
    build_ip_frame(itucv_pkg::IP_PROTO_TCP, itucv_pkg::IP_MIN_IHL, 4, -1);
    put_word(itucv_pkg::OFF_TLEN_HI, 16'd8);
    send_frame();
  endtask

  initial begin
    sb = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    run_directed_frames();
    while (rand_bytes < RANDOM_BYTES || rand_frames < MIN_RANDOM_FRAMES) begin
      if (rand_bytes >= 2 * RANDOM_BYTES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (rand_bytes >= RANDOM_BYTES / 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 12;
      end
      build_random_frame();
      rand_bytes += frame_q.size();
      rand_frames++;
      send_frame();
    end
    in_valid <= 1'b0;
    in_last_byte <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
